@@ src/fsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framed SPI sync reader package
// Shared constants, result record and the push record between engine and queue.
// ----------------------------------------------------------------------------
package fsr_pkg;

	localparam int FRAME_BYTES = 4;

	localparam logic [7:0] CMD_BYTE      = 8'h80;
	localparam logic [7:0] FILL_BYTE     = 8'h55;
	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] RETRY_DEFAULT = 8'd8;
	localparam logic [6:0] HEAD_FRAMES   = 7'd2;

	localparam logic [1:0] LAST_BYTE_IDX = 2'(FRAME_BYTES - 1);

	// Input action codes.
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Register address bit (word index) of the retry limit.
	localparam logic ADDR_RETRY_LIMIT = 1'b0;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       new_frame;
		logic       pause_before;
		logic       is_last;
	} result_t;

	// Up to two results produced by one accepted item.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] value,
			input logic new_frame, input logic pause_before, input logic is_last);
		result_t r;
		r.kind         = kind;
		r.value        = value;
		r.new_frame    = new_frame;
		r.pause_before = pause_before;
		r.is_last      = is_last;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/framed_spi_sync_reader_top.sv @@
`default_nettype none
// A result is registered in the result queue before it reaches the master side.
// Throughput: one item per cycle while each item yields one result and m_tready
// stays high; an item that yields a data byte and a frame byte gives two results,
// as the master side carries one result per beat out of a four-entry result queue.
// Reset: arst_n clears all transaction state at once; retry_limit returns to 8.
// ----------------------------------------------------------------------------
// Framed SPI sync reader top level
// Streaming front end, APB register and the frame/sync engine with its queue.
// ----------------------------------------------------------------------------
module framed_spi_sync_reader_top
	import fsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] max_length, [15:8] miso_byte
	input  wire logic        s_tuser,  // [0] action
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [7:0] value, [8] new_frame, [9] pause_before
	output logic [1:0]       m_tuser,  // [1:0] kind
	output logic             m_tlast,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       retry_limit_q;
	logic [7:0] retry_limit_val_q;
	logic       cfg_wr;
	logic       in_beat;
	logic       room;
	push_t      push;
	result_t    out_res;

	// The register port never stalls; a write lands on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_RETRY_LIMIT);
	assign prdata = (paddr[2] == ADDR_RETRY_LIMIT) ? {24'd0, retry_limit_val_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_val_q <= RETRY_DEFAULT;
			retry_limit_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				retry_limit_val_q <= pwdata[7:0];
			end
			// Marks the cycle after a register write, for checking only.
			retry_limit_q <= cfg_wr;
		end
	end

	// A beat is taken whenever the queue can absorb the worst case of two
	// results, so the input side keeps moving while results wait downstream.
	assign s_tready = room;
	assign in_beat  = s_tvalid && s_tready;

	fsr_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_beat),
		.action     (s_tuser),
		.max_length (s_tdata[7:0]),
		.miso_byte  (s_tdata[15:8]),
		.retry_limit(retry_limit_val_q),
		.push       (push)
	);

	fsr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.pause_before, out_res.new_frame, out_res.value};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.is_last;

`ifndef ASSERT_OFF
	// A start always produces its command byte right away.
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tuser == ACT_START) |=> m_tvalid)
		else $error("no result after an accepted start");

	// A stalled input side means results are waiting downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with nothing queued");

	// A register write is visible on the next cycle.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		retry_limit_q |-> (retry_limit_val_q == $past(pwdata[7:0])))
		else $error("retry limit write lost");
`endif

endmodule
`default_nettype wire

@@ src/fsr_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framed SPI sync reader engine
// Transaction state and the per-byte update that yields up to two results.
// ----------------------------------------------------------------------------
module fsr_engine
	import fsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       action,
	input  wire logic [7:0] max_length,
	input  wire logic [7:0] miso_byte,
	input  wire logic [7:0] retry_limit,
	output push_t           push
);

	logic       busy_q, busy_d;
	logic [6:0] frame_index_q, frame_index_d;
	logic [1:0] byte_index_q, byte_index_d;
	logic [6:0] frames_total_q, frames_total_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] final_count_q, final_count_d;
	logic [7:0] retries_left_q, retries_left_d;
	logic       sync_seen_q, sync_seen_d;
	logic       query_mode_q, query_mode_d;

	logic [7:0] min_len;
	logic [6:0] sync_frames;
	logic       give_data;
	result_t    frame_res;

	assign min_len     = (miso_byte < bytes_left_q) ? miso_byte : bytes_left_q;
	assign sync_frames = 7'(({1'b0, miso_byte} + 9'd3) >> 2) + HEAD_FRAMES;

	always_comb begin
		busy_d         = busy_q;
		frame_index_d  = frame_index_q;
		byte_index_d   = byte_index_q;
		frames_total_d = frames_total_q;
		bytes_left_d   = bytes_left_q;
		final_count_d  = final_count_q;
		retries_left_d = retries_left_q;
		sync_seen_d    = sync_seen_q;
		query_mode_d   = query_mode_q;
		give_data      = 1'b0;
		frame_res      = '0;
		push           = '0;
		if (accept) begin
			if (action == ACT_START) begin
				busy_d         = 1'b1;
				frame_index_d  = '0;
				byte_index_d   = '0;
				frames_total_d = HEAD_FRAMES;
				bytes_left_d   = max_length;
				final_count_d  = '0;
				retries_left_d = retry_limit;
				sync_seen_d    = 1'b1;
				query_mode_d   = (max_length == 8'd0);
				push.cnt       = 2'd1;
				push.r0        = make_result(KIND_SEND, CMD_BYTE, 1'b1, 1'b0, 1'b1);
			end else if (busy_q) begin
				// Payload frames hand out data; header frames check for sync.
				if (frame_index_q > 7'd1) begin
					if (bytes_left_q != 8'd0) begin
						give_data    = 1'b1;
						bytes_left_d = bytes_left_q - 8'd1;
					end
				end else if (retries_left_q != 8'd0) begin
					if (byte_index_q != LAST_BYTE_IDX) begin
						if (miso_byte != SYNC_BYTE) begin
							sync_seen_d = 1'b0;
						end
					end else if (sync_seen_q) begin
						if (query_mode_q) begin
							frames_total_d = HEAD_FRAMES;
							final_count_d  = miso_byte;
						end else begin
							frames_total_d = sync_frames;
							final_count_d  = min_len;
							bytes_left_d   = min_len;
						end
						retries_left_d = '0;
					end else begin
						frame_index_d  = '0;
						retries_left_d = retries_left_q - 8'd1;
					end
				end

				if (byte_index_q == LAST_BYTE_IDX) begin
					byte_index_d  = '0;
					frame_index_d = frame_index_d + 7'd1;
					sync_seen_d   = 1'b1;
					if (frame_index_d >= frames_total_d) begin
						busy_d    = 1'b0;
						frame_res = make_result(KIND_DONE, final_count_d, 1'b0, 1'b0, 1'b1);
					end else begin
						frame_res = make_result(KIND_SEND, FILL_BYTE, 1'b1,
							frame_index_d == 7'd1, 1'b1);
					end
				end else begin
					byte_index_d = byte_index_q + 2'd1;
					frame_res = make_result(KIND_SEND,
						(frame_index_d == 7'd0 && byte_index_d == 2'd1) ? bytes_left_d : FILL_BYTE,
						1'b0, 1'b0, 1'b1);
				end

				if (give_data) begin
					push.cnt = 2'd2;
					push.r0  = make_result(KIND_DATA, miso_byte, 1'b0, 1'b0, 1'b0);
					push.r1  = frame_res;
				end else begin
					push.cnt = 2'd1;
					push.r0  = frame_res;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			frame_index_q  <= '0;
			byte_index_q   <= '0;
			frames_total_q <= HEAD_FRAMES;
			bytes_left_q   <= '0;
			final_count_q  <= '0;
			retries_left_q <= RETRY_DEFAULT;
			sync_seen_q    <= 1'b1;
			query_mode_q   <= 1'b0;
		end else begin
			busy_q         <= busy_d;
			frame_index_q  <= frame_index_d;
			byte_index_q   <= byte_index_d;
			frames_total_q <= frames_total_d;
			bytes_left_q   <= bytes_left_d;
			final_count_q  <= final_count_d;
			retries_left_q <= retries_left_d;
			sync_seen_q    <= sync_seen_d;
			query_mode_q   <= query_mode_d;
		end
	end

`ifndef ASSERT_OFF
	// A running transaction always has frames still to go.
	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (frame_index_q < frames_total_q))
		else $error("frame index reached frame total while busy");

	// Idle only ever follows a frame boundary.
	a_idle_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (byte_index_q == 2'd0))
		else $error("engine idle in the middle of a frame");

	// The two header frames always run.
	a_min_frames: assert property (@(posedge clk) disable iff (!arst_n)
		frames_total_q >= HEAD_FRAMES)
		else $error("frame total below header frame count");
`endif

endmodule
`default_nettype wire

@@ src/fsr_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framed SPI sync reader result queue
// Four-entry queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module fsr_outq
	import fsr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	output logic      room,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_res
);

	localparam int DEPTH = 4;

	result_t    entries_q [DEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 3'd0);
	assign out_res   = entries_q[rd_q];
	assign pop       = out_valid && out_ready;
	// Room for the worst case of two results from one item.
	assign room      = (cnt_q <= 3'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entries_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			entries_q[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.cnt;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.cnt} - {2'b00, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> ({1'b0, cnt_q} + {2'b00, push.cnt} <= 4'(DEPTH)))
		else $error("push into a queue without room");

	a_pop_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> (cnt_q == $past(cnt_q) - 3'd1))
		else $error("queue level did not drop on pop");
`endif

endmodule
`default_nettype wire
